### design/random_byte_stream_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Random byte stream generator: assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// held off while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RANDOM_BYTE_STREAM_GENERATOR_TOP_MACROS_SVH
`define RANDOM_BYTE_STREAM_GENERATOR_TOP_MACROS_SVH

// Check that a condition holds at every sampled edge out of reset.
`define RBSG_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger at one edge is followed by a condition at the next.
`define RBSG_ASSERT_NEXT(lbl, clk, rst_n, trig, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

### design/rbsg_pkg.sv
// ----------------------------------------------------------------------------
// Random byte stream generator: package
// Command codes, microcode word layout, step program and generator constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbsg_pkg;

    // Commands carried in tuser
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_READ  = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_SEED  = 2'd2;

    // Generator select
    localparam logic MODE_MWC = 1'b0;
    localparam logic MODE_TMT = 1'b1;

    // Datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NOP   = 3'd0;
    localparam t_op OP_MWC   = 3'd1;
    localparam t_op OP_HASH  = 3'd2;
    localparam t_op OP_TLOAD = 3'd3;
    localparam t_op OP_TINIT = 3'd4;
    localparam t_op OP_TCERT = 3'd5;
    localparam t_op OP_TADV  = 3'd6;
    localparam t_op OP_TTEMP = 3'd7;

    // Sequencing after a step
    typedef logic [1:0] t_br;
    localparam t_br BR_NEXT = 2'd0;
    localparam t_br BR_JUMP = 2'd1;
    localparam t_br BR_LOOP = 2'd2;
    localparam t_br BR_END  = 2'd3;

    localparam int STEP_W = 4;
    localparam int CNT_W  = 3;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        t_op   op;
        t_br   br;
        t_step target;
        t_cnt  limit;
    } t_uword;

    typedef struct packed {
        logic en;
        logic done;
        t_op  op;
        t_cnt cnt;
    } t_dp_ctl;

    // Program entry points
    localparam t_step ENT_RD_MWC = 4'd0;
    localparam t_step ENT_RD_TMT = 4'd1;
    localparam t_step ENT_WR     = 4'd3;
    localparam t_step ENT_SEED   = 4'd4;
    localparam t_step STEP_INIT  = 4'd5;
    localparam t_step STEP_WARM  = 4'd7;
    localparam t_step ENT_END    = 4'd8;

    localparam t_cnt INIT_LAST = 3'd6;
    localparam t_cnt WARM_LAST = 3'd7;
    localparam t_cnt CNT_NONE  = 3'd0;

    // Generator constants
    localparam logic [15:0] MWC_Z_MUL    = 16'd36969;
    localparam logic [15:0] MWC_W_MUL    = 16'd18000;
    localparam logic [31:0] MWC_Z_ZERO   = 32'd1;
    localparam logic [31:0] MWC_W_ZERO   = 32'd2;
    localparam logic [31:0] TMT_MASK     = 32'h7fff_ffff;
    localparam logic [31:0] TMT_INIT_MUL = 32'd1812433253;
    localparam logic [31:0] TMT_FIX0     = 32'h0000_0054;
    localparam logic [31:0] TMT_FIX1     = 32'h0000_0049;
    localparam logic [31:0] TMT_FIX2     = 32'h0000_004e;
    localparam logic [31:0] TMT_FIX3     = 32'h0000_0059;

    // Step program: one control word per step
    function automatic t_uword ucode_rom(input t_step pc);
        t_uword w;
        w = '{op: OP_NOP, br: BR_END, target: ENT_END, limit: CNT_NONE};
        unique case (pc)
            4'd0:    w = '{op: OP_MWC,   br: BR_JUMP, target: ENT_END,   limit: CNT_NONE};
            4'd1:    w = '{op: OP_TADV,  br: BR_NEXT, target: ENT_END,   limit: CNT_NONE};
            4'd2:    w = '{op: OP_TTEMP, br: BR_JUMP, target: ENT_END,   limit: CNT_NONE};
            4'd3:    w = '{op: OP_HASH,  br: BR_JUMP, target: ENT_END,   limit: CNT_NONE};
            4'd4:    w = '{op: OP_TLOAD, br: BR_NEXT, target: ENT_END,   limit: CNT_NONE};
            4'd5:    w = '{op: OP_TINIT, br: BR_LOOP, target: STEP_INIT, limit: INIT_LAST};
            4'd6:    w = '{op: OP_TCERT, br: BR_NEXT, target: ENT_END,   limit: CNT_NONE};
            4'd7:    w = '{op: OP_TADV,  br: BR_LOOP, target: STEP_WARM, limit: WARM_LAST};
            4'd8:    w = '{op: OP_NOP,   br: BR_END,  target: ENT_END,   limit: CNT_NONE};
            default: w = '{op: OP_NOP,   br: BR_END,  target: ENT_END,   limit: CNT_NONE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### design/rbsg_useq.sv
// ----------------------------------------------------------------------------
// Random byte stream generator: step sequencer
// Step and loop counters and program ROM; while busy, one control word a cycle unless the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbsg_useq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire rbsg_pkg::t_cmd     i_cmd,
    input  wire logic               i_mode,
    input  wire logic               i_out_free,
    output rbsg_pkg::t_dp_ctl       o_ctl,
    output logic                    o_busy
);

    logic              r_busy;
    rbsg_pkg::t_step   r_pc;
    rbsg_pkg::t_cnt    r_cnt;
    rbsg_pkg::t_step   n_entry;
    rbsg_pkg::t_uword  w_uw;
    logic              w_loop;
    logic              w_end;
    logic              w_en;

    // Pick the program for the accepted command
    always_comb begin
        unique case (i_cmd)
            rbsg_pkg::CMD_READ:  n_entry = (i_mode == rbsg_pkg::MODE_TMT) ?
                                           rbsg_pkg::ENT_RD_TMT : rbsg_pkg::ENT_RD_MWC;
            rbsg_pkg::CMD_WRITE: n_entry = rbsg_pkg::ENT_WR;
            rbsg_pkg::CMD_SEED:  n_entry = (i_mode == rbsg_pkg::MODE_TMT) ?
                                           rbsg_pkg::ENT_SEED : rbsg_pkg::ENT_END;
            default:             n_entry = rbsg_pkg::ENT_END;
        endcase
    end

    always_comb begin
        w_uw   = rbsg_pkg::ucode_rom(r_pc);
        w_loop = (w_uw.br == rbsg_pkg::BR_LOOP) && (r_cnt != w_uw.limit);
        w_end  = (w_uw.br == rbsg_pkg::BR_END);
        // hold the final step until the result register can take the item
        w_en   = r_busy && (!w_end || i_out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= rbsg_pkg::ENT_END;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pc   <= n_entry;
            r_cnt  <= '0;
        end else if (w_en) begin
            unique case (w_uw.br)
                rbsg_pkg::BR_LOOP: begin
                    if (w_loop) begin
                        r_pc  <= w_uw.target;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_pc  <= r_pc + 1'b1;
                        r_cnt <= '0;
                    end
                end
                rbsg_pkg::BR_JUMP: begin
                    r_pc  <= w_uw.target;
                    r_cnt <= '0;
                end
                rbsg_pkg::BR_END: begin
                    r_busy <= 1'b0;
                end
                default: begin
                    r_pc  <= r_pc + 1'b1;
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_ctl.en   = w_en;
    assign o_ctl.done = w_en && w_end;
    assign o_ctl.op   = w_uw.op;
    assign o_ctl.cnt  = r_cnt;
    assign o_busy     = r_busy;

endmodule

`default_nettype wire

### design/rbsg_dp.sv
// ----------------------------------------------------------------------------
// Random byte stream generator: datapath
// Generator state, seed hash and prefetched byte, updated one operation a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbsg_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rbsg_pkg::t_dp_ctl  i_ctl,
    input  wire logic               i_mode,
    input  wire logic               i_load,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic [31:0]        i_seed_word,
    input  wire logic [31:0]        i_mat1_word,
    input  wire logic [31:0]        i_mat2_word,
    input  wire logic [31:0]        i_tmat_word,
    output logic [7:0]              o_next_byte
);

    localparam logic [31:0] MWC_Z_MUL_EXT = {16'd0, rbsg_pkg::MWC_Z_MUL};
    localparam logic [31:0] MWC_W_MUL_EXT = {16'd0, rbsg_pkg::MWC_W_MUL};

    // Operands latched with the item
    logic [7:0]  r_byte;
    logic [31:0] r_seed;
    logic [31:0] r_m1;
    logic [31:0] r_m2;
    logic [31:0] r_tm;

    // Architectural state
    logic [31:0] r_hash;
    logic [31:0] r_z;
    logic [31:0] r_w;
    logic [31:0] r_st [4];
    logic [31:0] r_mat1;
    logic [31:0] r_mat2;
    logic [31:0] r_tmat;
    logic [7:0]  r_next_byte;

    logic [31:0] w_z_prod, w_w_prod, w_z_new, w_w_new;
    logic [31:0] w_hash_new;
    logic [2:0]  w_idx;
    logic [31:0] w_pt, w_init_prod, w_init_new;
    logic [31:0] w_x, w_y, w_adv1, w_adv2;
    logic [31:0] w_t1, w_t0;
    logic        w_all_zero;

    always_comb begin
        // multiply-with-carry halves
        w_z_prod   = MWC_Z_MUL_EXT * {16'd0, r_z[15:0]};
        w_w_prod   = MWC_W_MUL_EXT * {16'd0, r_w[15:0]};
        w_z_new    = w_z_prod + {16'd0, r_z[31:16]};
        w_w_new    = w_w_prod + {16'd0, r_w[31:16]};
        // seed hash fold
        w_hash_new = r_hash * {r_hash[23:0], 8'h00} + {24'd0, r_byte};
        // init iteration on the rotated status: slot 0 is the previous word
        w_idx       = i_ctl.cnt + 3'd1;
        w_pt        = r_st[0] ^ (r_st[0] >> 30);
        w_init_prod = w_pt * rbsg_pkg::TMT_INIT_MUL;
        w_init_new  = r_st[1] ^ (w_init_prod + {29'd0, w_idx});
        // state transition
        w_x    = (r_st[0] & rbsg_pkg::TMT_MASK) ^ r_st[1] ^ r_st[2];
        w_x    = w_x ^ (w_x << 1);
        w_y    = r_st[3] ^ (r_st[3] >> 1) ^ w_x;
        w_adv1 = r_st[2] ^ (w_y[0] ? r_mat1 : 32'd0);
        w_adv2 = w_x ^ (w_y << 10) ^ (w_y[0] ? r_mat2 : 32'd0);
        // tempering
        w_t1 = r_st[0] + (r_st[2] >> 8);
        w_t0 = r_st[3] ^ w_t1 ^ (w_t1[0] ? r_tmat : 32'd0);
        // after seven rotations word k sits in slot (k+1) mod 4
        w_all_zero = ((r_st[1] & rbsg_pkg::TMT_MASK) == 32'd0) && (r_st[2] == 32'd0) &&
                     (r_st[3] == 32'd0) && (r_st[0] == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_data_byte;
            r_seed <= i_seed_word;
            r_m1   <= i_mat1_word;
            r_m2   <= i_mat2_word;
            r_tm   <= i_tmat_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= 32'd0;
            r_z         <= 32'd1;
            r_w         <= 32'd2;
            r_st[0]     <= 32'd0;
            r_st[1]     <= 32'd0;
            r_st[2]     <= 32'd0;
            r_st[3]     <= 32'd0;
            r_mat1      <= 32'd0;
            r_mat2      <= 32'd0;
            r_tmat      <= 32'd0;
            r_next_byte <= 8'd0;
        end else if (i_ctl.en) begin
            case (i_ctl.op)
                rbsg_pkg::OP_MWC: begin
                    r_z         <= w_z_new;
                    r_w         <= w_w_new;
                    // (z << 16) leaves the low byte to w
                    r_next_byte <= w_w_new[7:0];
                end
                rbsg_pkg::OP_HASH: begin
                    r_hash <= w_hash_new;
                    if (i_mode == rbsg_pkg::MODE_MWC) begin
                        r_z <= (w_hash_new == 32'd0) ? rbsg_pkg::MWC_Z_ZERO : w_hash_new;
                        r_w <= (r_hash == 32'd0) ? rbsg_pkg::MWC_W_ZERO : r_hash;
                    end
                end
                rbsg_pkg::OP_TLOAD: begin
                    r_hash  <= r_seed;
                    r_mat1  <= r_m1;
                    r_mat2  <= r_m2;
                    r_tmat  <= r_tm;
                    r_st[0] <= r_seed;
                    r_st[1] <= r_m1;
                    r_st[2] <= r_m2;
                    r_st[3] <= r_tm;
                end
                rbsg_pkg::OP_TINIT: begin
                    // update the target word and rotate it into the previous slot
                    r_st[0] <= w_init_new;
                    r_st[1] <= r_st[2];
                    r_st[2] <= r_st[3];
                    r_st[3] <= r_st[0];
                end
                rbsg_pkg::OP_TCERT: begin
                    if (w_all_zero) begin
                        r_st[0] <= rbsg_pkg::TMT_FIX0;
                        r_st[1] <= rbsg_pkg::TMT_FIX1;
                        r_st[2] <= rbsg_pkg::TMT_FIX2;
                        r_st[3] <= rbsg_pkg::TMT_FIX3;
                    end else begin
                        r_st[0] <= r_st[1];
                        r_st[1] <= r_st[2];
                        r_st[2] <= r_st[3];
                        r_st[3] <= r_st[0];
                    end
                end
                rbsg_pkg::OP_TADV: begin
                    r_st[0] <= r_st[1];
                    r_st[1] <= w_adv1;
                    r_st[2] <= w_adv2;
                    r_st[3] <= w_y;
                end
                rbsg_pkg::OP_TTEMP: begin
                    r_next_byte <= w_t0[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_next_byte = r_next_byte;

endmodule

`default_nettype wire

### design/random_byte_stream_generator_top.sv
// ----------------------------------------------------------------------------
// Random byte stream generator: top level
// A read steps the generator (TinyMT: advance, then temper), a byte write folds
// the seed hash, a TinyMT seed loads, initialises, certifies and warms up the
// state; one item in work at a time. Synchronous reset; items taken right after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "random_byte_stream_generator_top_macros.svh"

// Synchronous active-low reset clears the generator state (hash 0, z 1, w 2,
// TinyMT words 0, prefetched byte 0), the mode register and all handshake
// state. No clearing pass: the block takes items on the cycle after reset.
//
// An accepted item starts a short program in the sequencer; the datapath runs
// one operation per step. The result sits in an output register, so a new
// item is taken while a finished result still waits downstream.

module random_byte_stream_generator_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration: generator_mode
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_data,
    // command items
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata: data_byte[7:0], seed_word[39:8], mat1_word[71:40],
    //        mat2_word[103:72], tmat_word[135:104]
    input  wire logic [135:0] i_s_axis_tdata,
    // tuser: cmd[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    // result items
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata: read_byte[7:0], peek_byte[15:8]
    output logic [15:0]       o_m_axis_tdata
);

    logic              r_mode;
    logic              r_out_valid;
    logic [7:0]        r_out_read;
    logic [7:0]        r_out_peek;
    logic [7:0]        r_rd;

    logic              w_s_accept;
    logic              w_out_free;
    logic              w_busy;
    logic [7:0]        w_next_byte;
    rbsg_pkg::t_dp_ctl w_ctl;

    // Mode writes must land only while idle; the user keeps to this, the block does not enforce it. Ready is tied high.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rbsg_pkg::MODE_MWC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Take a new item whenever the sequencer is free
    assign o_s_axis_tready = !w_busy;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    rbsg_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_s_accept),
        .i_cmd      (i_s_axis_tuser),
        .i_mode     (r_mode),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy)
    );

    rbsg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_mode      (r_mode),
        .i_load      (w_s_accept),
        .i_data_byte (i_s_axis_tdata[7:0]),
        .i_seed_word (i_s_axis_tdata[39:8]),
        .i_mat1_word (i_s_axis_tdata[71:40]),
        .i_mat2_word (i_s_axis_tdata[103:72]),
        .i_tmat_word (i_s_axis_tdata[135:104]),
        .o_next_byte (w_next_byte)
    );

    // Capture the byte a read returns before its prefetch replaces it
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_rd <= (i_s_axis_tuser == rbsg_pkg::CMD_READ) ? w_next_byte : 8'd0;
        end
    end

    // Result register: load on the final step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.done) begin
            r_out_read <= r_rd;
            r_out_peek <= w_next_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_peek, r_out_read};

    // An accepted item always occupies the sequencer on the next cycle
    `RBSG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_s_accept, w_busy, "item lost at start")
    // A program never finishes onto a result that is still held downstream
    `RBSG_ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n,
        !(w_ctl.done && r_out_valid && !i_m_axis_tready), "result overwritten")
    // Finishing a program frees the sequencer and shows the result
    `RBSG_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, w_ctl.done,
        (!w_busy || w_s_accept) && o_m_axis_tvalid, "result not presented")

endmodule

`default_nettype wire
